/* hdl/tsd_pkg.sv */
// Shared types and constants for the degree-input Taylor sine block.
// No dependencies; imported by the cell and the top level.
`default_nettype none

package tsd_pkg;

  // fixed port widths
  localparam int unsigned DEG_W    = 16;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned OUT_FRAC = 28;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  // register map: index is paddr[2]
  localparam logic REG_TERM_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] TERM_COUNT_RESET = CNT_W'(8);

  // pi/180 in Q0.40, applied to Q10.6 degrees
  localparam int unsigned RAD_W    = 35;
  localparam logic [RAD_W-1:0] RAD_FACTOR = 35'd19190098069;
  localparam int unsigned RAD_FRAC = 46;

  // integer headroom above FRAC_BITS for the internal magnitudes
  localparam int unsigned X_XW    = 4;   // |x| < 9 rad
  localparam int unsigned X2_XW   = 7;   // x^2 < 81
  localparam int unsigned TERM_XW = 12;  // largest term stays near 1000
  localparam int unsigned PROD_XW = 19;  // term * x^2
  localparam int unsigned SUM_XW  = 16;  // signed running sum

  typedef struct packed {
    logic             valid;
    logic             neg;    // sign of the term held with this word
    logic [CNT_W-1:0] count;  // terms to sum for this word
  } tsd_ctl_t;

endpackage

`default_nettype wire

/* hdl/tsd_mul.sv */
// Four-stage unsigned multiplier: four half-width partial products, then
// round half up, shift right and saturate. Carries a side word along.
`default_nettype none

module tsd_mul #(
  parameter int unsigned AW  = 16,
  parameter int unsigned BW  = 16,
  parameter int unsigned SH  = 8,
  parameter int unsigned OW  = 24,
  parameter int unsigned SDW = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [AW-1:0]  a_i,
  input  wire logic [BW-1:0]  b_i,
  input  wire logic [SDW-1:0] side_i,
  output logic                valid_o,
  output logic [OW-1:0]       p_o,
  output logic [SDW-1:0]      side_o
);

  localparam int unsigned HA  = (AW + 1) / 2;
  localparam int unsigned HB  = (BW + 1) / 2;
  localparam int unsigned PRW = AW + BW + 1;
  localparam logic [PRW-1:0] RND = PRW'(1) << (SH - 1);

  logic v1_q, v2_q, v3_q, v4_q;
  logic [AW-1:0]  a1_q;
  logic [AW-1:HA] a2_q, a3_q;
  logic [BW-1:0]  b1_q, b2_q;
  logic [BW-1:HB] b3_q;
  logic [SDW-1:0] s1_q, s2_q, s3_q, s4_q;
  logic [PRW-1:0] acc1_q, acc2_q, acc3_q;
  logic [PRW-1:0] acc1_d, acc2_d, acc3_d, acc4;
  logic [PRW-1:0] shv;
  logic [OW-1:0]  p_d, p_q;
  logic           ovf;

  logic [HA+HB-1:0]           pp0;
  logic [HA+BW-HB-1:0]        pp1;
  logic [AW-HA+HB-1:0]        pp2;
  logic [AW-HA+BW-HB-1:0]     pp3;

  assign pp0    = a_i[HA-1:0] * b_i[HB-1:0];
  assign acc1_d = PRW'(pp0);
  assign pp1    = a1_q[HA-1:0] * b1_q[BW-1:HB];
  assign acc2_d = acc1_q + (PRW'(pp1) << HB);
  assign pp2    = a2_q * b2_q[HB-1:0];
  assign acc3_d = acc2_q + (PRW'(pp2) << HA);
  assign pp3    = a3_q * b3_q;
  assign acc4   = acc3_q + (PRW'(pp3) << (HA + HB)) + RND;
  assign shv    = acc4 >> SH;
  assign ovf    = |(shv >> OW);
  assign p_d    = ovf ? '1 : OW'(shv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q   <= a_i;
      b1_q   <= b_i;
      s1_q   <= side_i;
      acc1_q <= acc1_d;
      a2_q   <= a1_q[AW-1:HA];
      b2_q   <= b1_q;
      s2_q   <= s1_q;
      acc2_q <= acc2_d;
      a3_q   <= a2_q;
      b3_q   <= b2_q[BW-1:HB];
      s3_q   <= s2_q;
      acc3_q <= acc3_d;
      p_q    <= p_d;
      s4_q   <= s3_q;
    end
  end

  assign valid_o = v4_q;
  assign p_o     = p_q;
  assign side_o  = s4_q;

endmodule

`default_nettype wire

/* hdl/tsd_cell.sv */
// One Taylor term cell: next term = prev * x^2 * 1/((2n)(2n+1)), then adds
// it to the running sum when n is below the word's count. Uses tsd_mul, tsd_pkg.
`default_nettype none

module tsd_cell
  import tsd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 28,
  parameter int unsigned IDX       = 1
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   en_i,
  input  wire tsd_ctl_t                               ctl_i,
  input  wire logic [FRAC_BITS+TERM_XW-1:0]           term_i,
  input  wire logic [FRAC_BITS+X2_XW-1:0]             x2_i,
  input  wire logic signed [FRAC_BITS+SUM_XW-1:0]     sum_i,
  output tsd_ctl_t                                    ctl_o,
  output logic [FRAC_BITS+TERM_XW-1:0]                term_o,
  output logic [FRAC_BITS+X2_XW-1:0]                  x2_o,
  output logic signed [FRAC_BITS+SUM_XW-1:0]          sum_o
);

  localparam int unsigned TW  = FRAC_BITS + TERM_XW;
  localparam int unsigned X2W = FRAC_BITS + X2_XW;
  localparam int unsigned PW  = FRAC_BITS + PROD_XW;
  localparam int unsigned SW  = FRAC_BITS + SUM_XW;
  localparam int unsigned RW  = FRAC_BITS - 2;
  localparam int unsigned SDW = 1 + CNT_W + X2W + SW;
  localparam longint unsigned DEN   = 64'(2 * IDX * (2 * IDX + 1));
  localparam longint unsigned RECIP = ((64'd1 << FRAC_BITS) + DEN / 2) / DEN;

  logic           va, vb;
  logic [PW-1:0]  pa;
  logic [TW-1:0]  tb;
  logic [SDW-1:0] sa, sb;

  logic                   b_neg;
  logic [CNT_W-1:0]       b_count;
  logic [X2W-1:0]         b_x2;
  logic signed [SW-1:0]   b_sum, t_s, sum_d;
  logic                   neg_d, add_en;

  logic                   valid_q, neg_q;
  logic [CNT_W-1:0]       count_q;
  logic [TW-1:0]          term_q;
  logic [X2W-1:0]         x2_q;
  logic signed [SW-1:0]   sum_q;

  tsd_mul #(.AW(TW), .BW(X2W), .SH(FRAC_BITS), .OW(PW), .SDW(SDW)) u_mul_x2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (ctl_i.valid),
    .a_i     (term_i),
    .b_i     (x2_i),
    .side_i  ({ctl_i.neg, ctl_i.count, x2_i, sum_i}),
    .valid_o (va),
    .p_o     (pa),
    .side_o  (sa)
  );

  tsd_mul #(.AW(PW), .BW(RW), .SH(FRAC_BITS), .OW(TW), .SDW(SDW)) u_mul_rcp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (va),
    .a_i     (pa),
    .b_i     (RW'(RECIP)),
    .side_i  (sa),
    .valid_o (vb),
    .p_o     (tb),
    .side_o  (sb)
  );

  assign {b_neg, b_count, b_x2, b_sum} = sb;

  // term sign alternates
  assign neg_d  = !b_neg;
  assign add_en = b_count > CNT_W'(IDX);
  assign t_s    = signed'(SW'(tb));

  always_comb begin
    sum_d = b_sum;
    if (add_en) begin
      sum_d = neg_d ? b_sum - t_s : b_sum + t_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= vb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q   <= neg_d;
      count_q <= b_count;
      term_q  <= tb;
      x2_q    <= b_x2;
      sum_q   <= sum_d;
    end
  end

  always_comb begin
    ctl_o.valid = valid_q;
    ctl_o.neg   = neg_q;
    ctl_o.count = count_q;
  end

  assign term_o = term_q;
  assign x2_o   = x2_q;
  assign sum_o  = sum_q;

endmodule

`default_nettype wire

/* hdl/taylor_sine_degrees_top.sv */
// Top level of the degree-input Taylor sine block: APB register, degree to
// radian conversion, x^2, chain of term cells and output rounding/saturation.
// Depends on tsd_pkg, tsd_mul and tsd_cell.
`default_nettype none

// Takes Q10.6 degrees and returns sin in Q3.28 from the first term_count
// Taylor terms (capped at MAX_TERMS; zero terms give 0), saturated. The
// datapath is a chain of MAX_TERMS-1 cells, one per term after the first,
// each with two four-stage multipliers and an add stage, behind a
// four-stage radian conversion and a four-stage x^2 multiplier. One word
// is accepted per cycle while no output result is stalled.
// term_count is sampled when a word is accepted. A stalled result freezes
// the whole chain and stalls the input.
module taylor_sine_degrees_top
  import tsd_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 16,
  parameter int unsigned FRAC_BITS = 28
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [DEG_W-1:0]  angle_degrees_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [OUT_W-1:0]       sine_value_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  localparam int unsigned XW    = FRAC_BITS + X_XW;
  localparam int unsigned X2W   = FRAC_BITS + X2_XW;
  localparam int unsigned TW    = FRAC_BITS + TERM_XW;
  localparam int unsigned SW    = FRAC_BITS + SUM_XW;
  localparam int unsigned LAST  = MAX_TERMS - 1;
  localparam int unsigned OSH_L = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
  localparam int unsigned OSH_R = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int unsigned MGW   = SW + OSH_L + 1;
  localparam logic [MGW-1:0] HALF_R  = (MGW'(1) << OSH_R) >> 1;
  localparam logic [MGW-1:0] POS_MAX = MGW'(32'h7FFF_FFFF);
  localparam logic [MGW-1:0] NEG_MAX = MGW'(33'h1_0000_0000 >> 1);

  // config register
  logic [CNT_W-1:0] term_count_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TERM_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TERM_COUNT_RESET;
    end else if (cfg_wr) begin
      term_count_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TERM_COUNT) begin
      prdata = DATA_W'(term_count_q);
    end
  end

  // global advance
  logic en, accept;
  logic out_valid_q;
  logic signed [OUT_W-1:0] out_value_q, out_value_d;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  // input: magnitude, sign, capped count
  logic             deg_neg;
  logic [DEG_W-1:0] deg_mag;
  logic [CNT_W-1:0] cnt;

  assign deg_neg = angle_degrees_i[DEG_W-1];
  assign deg_mag = deg_neg ? DEG_W'(-angle_degrees_i) : DEG_W'(angle_degrees_i);
  assign cnt     = ({1'b0, term_count_q} > (CNT_W + 1)'(MAX_TERMS)) ?
                   CNT_W'(MAX_TERMS) : term_count_q;

  // radians
  logic             xv;
  logic [XW-1:0]    xm;
  logic [CNT_W:0]   xs;

  tsd_mul #(.AW(DEG_W), .BW(RAD_W), .SH(RAD_FRAC - FRAC_BITS), .OW(XW),
            .SDW(CNT_W + 1)) u_mul_rad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (accept),
    .a_i     (deg_mag),
    .b_i     (RAD_FACTOR),
    .side_i  ({deg_neg, cnt}),
    .valid_o (xv),
    .p_o     (xm),
    .side_o  (xs)
  );

  // x^2
  logic                  x2v;
  logic [X2W-1:0]        x2m;
  logic [CNT_W+XW:0]     x2s;
  logic                  c0_neg;
  logic [CNT_W-1:0]      c0_count;
  logic [XW-1:0]         c0_x;
  logic signed [SW-1:0]  c0_xs;

  tsd_mul #(.AW(XW), .BW(XW), .SH(FRAC_BITS), .OW(X2W), .SDW(CNT_W + XW + 1)) u_mul_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (xv),
    .a_i     (xm),
    .b_i     (xm),
    .side_i  ({xs, xm}),
    .valid_o (x2v),
    .p_o     (x2m),
    .side_o  (x2s)
  );

  assign {c0_neg, c0_count, c0_x} = x2s;
  assign c0_xs = signed'(SW'(c0_x));

  // chain of term cells
  tsd_ctl_t             chain_ctl  [MAX_TERMS];
  logic [TW-1:0]        chain_term [MAX_TERMS];
  logic [X2W-1:0]       chain_x2   [MAX_TERMS];
  logic signed [SW-1:0] chain_sum  [MAX_TERMS];

  always_comb begin
    chain_ctl[0].valid = x2v;
    chain_ctl[0].neg   = c0_neg;
    chain_ctl[0].count = c0_count;
  end

  assign chain_term[0] = TW'(c0_x);
  assign chain_x2[0]   = x2m;
  assign chain_sum[0]  = c0_neg ? -c0_xs : c0_xs;

  for (genvar k = 1; k < MAX_TERMS; k++) begin : g_cell
    tsd_cell #(.FRAC_BITS(FRAC_BITS), .IDX(k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (chain_ctl[k-1]),
      .term_i (chain_term[k-1]),
      .x2_i   (chain_x2[k-1]),
      .sum_i  (chain_sum[k-1]),
      .ctl_o  (chain_ctl[k]),
      .term_o (chain_term[k]),
      .x2_o   (chain_x2[k]),
      .sum_o  (chain_sum[k])
    );
  end

  // Q3.28 rounding and saturation
  logic            s_neg;
  logic [SW-1:0]   mag;
  logic [MGW-1:0]  mag_r, mag_l;

  assign s_neg = chain_sum[LAST][SW-1];
  assign mag   = s_neg ? SW'(-chain_sum[LAST]) : SW'(chain_sum[LAST]);
  assign mag_r = (MGW'(mag) + HALF_R) >> OSH_R;
  assign mag_l = mag_r << OSH_L;

  always_comb begin
    if (chain_ctl[LAST].count == '0) begin
      out_value_d = '0;
    end else if (s_neg) begin
      out_value_d = (mag_l > NEG_MAX) ? signed'(32'h8000_0000) :
                    signed'(-mag_l[OUT_W-1:0]);
    end else begin
      out_value_d = (mag_l > POS_MAX) ? signed'(32'h7FFF_FFFF) :
                    signed'(mag_l[OUT_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_ctl[LAST].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_value_q <= out_value_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sine_value_o = out_value_q;

  // chain holds while the output is stalled
  a_chain_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(chain_ctl[LAST]) && $stable(chain_sum[LAST])))
    else $error("term chain moved during output stall");

  a_zero_terms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && chain_ctl[LAST].valid && chain_ctl[LAST].count == '0)
      |=> (out_valid_o && sine_value_o == '0))
    else $error("zero term count did not give zero");

  a_sign_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && chain_ctl[LAST].valid && !chain_sum[LAST][SW-1])
      |=> (out_valid_o && !sine_value_o[OUT_W-1]))
    else $error("non-negative sum gave negative word");

endmodule

`default_nettype wire

/* tb/sv/tb_taylor_sine_degrees_top.sv */
// Self-checking testbench for taylor_sine_degrees_top: directed table, then random angles
// over several term_count settings, with random input gaps and output stalls.
// Depends on tsd_pkg and the taylor_sine_degrees_top RTL only.
module tb_taylor_sine_degrees_top;
  import tsd_pkg::*;

  localparam int unsigned MAX_TERMS  = 16;
  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned DEG_FRAC   = 6;
  localparam int unsigned DEG_SHIFT  = 40 + DEG_FRAC - FRAC_BITS;
  localparam logic [63:0] DEG_TO_RAD = 64'd19190098069;  // pi/180, Q0.40
  localparam logic [63:0] MAG_LIMIT  = 64'h4000_0000_0000_0000;
  localparam logic [ADDR_W-1:0] ADDR_TERM_COUNT = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] ADDR_SPARE      = ADDR_W'(4);
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PHASE_WORDS = 160;
  localparam int unsigned PH_HOLD     = 2;
  localparam int unsigned PH_SPARE    = 4;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned LIMIT       = 300000;

  typedef struct packed {
    logic [CNT_W-1:0]        terms;
    logic signed [DEG_W-1:0] angle;
    logic                    known;
    logic [OUT_W-1:0]        sine;
  } dir_row_t;

  localparam int unsigned N_DIR = 24;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{5'd8,  16'sd0,      1'b1, 32'h0000_0000},
    '{5'd8,  16'sd5760,   1'b0, 32'h0},
    '{5'd8,  -16'sd5760,  1'b0, 32'h0},
    '{5'd8,  16'sd23040,  1'b0, 32'h0},
    '{5'd8,  -16'sd23040, 1'b0, 32'h0},
    '{5'd8,  16'sd1,      1'b0, 32'h0},
    '{5'd8,  -16'sd1,     1'b0, 32'h0},
    '{5'd8,  16'sd11520,  1'b0, 32'h0},
    '{5'd8,  16'sd2880,   1'b0, 32'h0},
    '{5'd0,  16'sd5760,   1'b1, 32'h0000_0000},
    '{5'd0,  16'h8000,    1'b1, 32'h0000_0000},
    '{5'd1,  16'h7FFF,    1'b1, 32'h7FFF_FFFF},
    '{5'd1,  16'h8000,    1'b1, 32'h8000_0000},
    '{5'd1,  16'sd5760,   1'b0, 32'h0},
    '{5'd2,  16'sd23040,  1'b1, 32'h8000_0000},
    '{5'd2,  -16'sd23040, 1'b1, 32'h7FFF_FFFF},
    '{5'd16, 16'sd23040,  1'b0, 32'h0},
    '{5'd16, 16'sd5760,   1'b0, 32'h0},
    '{5'd16, 16'h7FFF,    1'b0, 32'h0},
    '{5'd17, 16'sd5760,   1'b0, 32'h0},
    '{5'd17, 16'h8000,    1'b0, 32'h0},
    '{5'd31, 16'sd23040,  1'b0, 32'h0},
    '{5'd31, -16'sd11520, 1'b0, 32'h0},
    '{5'd5,  16'sd1234,   1'b0, 32'h0}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [DEG_W-1:0] angle_degrees_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] sine_value_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  logic [OUT_W-1:0] pending_sines [$];
  logic [CNT_W-1:0] cur_terms = CNT_W'(8);
  int unsigned      mismatches = 0;
  int unsigned      cycle_cnt = 0;
  bit               tx_gaps = 1'b1;
  bit               rx_gaps = 1'b1;
  bit               long_hold_req = 1'b0;

  taylor_sine_degrees_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .angle_degrees_i (angle_degrees_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sine_value_o    (sine_value_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // round(ua*ub / 2^sh) half away from zero, clamped
  function automatic logic [63:0] scaled_mag(input logic [63:0] ua, input logic [63:0] ub,
                                             input int unsigned sh);
    logic [127:0] p;
    p = {64'd0, ua} * {64'd0, ub};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    if (p > {64'd0, MAG_LIMIT}) return MAG_LIMIT;
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [63:0] ma, mb, m;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    m  = scaled_mag(ma, mb, FRAC_BITS);
    return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [OUT_W-1:0] taylor_sine(input logic signed [DEG_W-1:0] ang,
                                                   input logic [CNT_W-1:0] cnt);
    logic signed [63:0] deg, x, x2, term, acc, recip;
    logic [63:0]        xm, d;
    int unsigned        n, terms;
    terms = (cnt > MAX_TERMS) ? MAX_TERMS : cnt;
    if (terms == 0) return '0;
    deg  = ang;
    xm   = scaled_mag((deg < 0) ? 64'(-deg) : 64'(deg), DEG_TO_RAD, DEG_SHIFT);
    x    = (deg < 0) ? -$signed(xm) : $signed(xm);
    x2   = qmul(x, x);
    term = x;
    acc  = x;
    for (n = 1; n < terms; n++) begin
      d     = 64'(2 * n) * 64'(2 * n + 1);
      recip = $signed(((64'd1 << FRAC_BITS) + d / 2) / d);
      term  = -qmul(qmul(term, x2), recip);
      acc   = acc + term;
    end
    if (acc > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (acc < -64'sd2147483648) return 32'h8000_0000;
    return acc[OUT_W-1:0];
  endfunction

  function automatic logic signed [DEG_W-1:0] pick_angle();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return DEG_W'(int'($urandom_range(0, 46080)) - 23040);
    if (sel < 8) return DEG_W'($urandom());
    if (sel == 8) return DEG_W'(int'($urandom_range(0, 64)) - 32);
    return DEG_W'(($urandom_range(0, 1) ? 23040 : -23040) + int'($urandom_range(0, 8)) - 4);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycle_cnt, msg);
    mismatches++;
  endtask

  task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_terms(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] wdata);
    logic [DATA_W-1:0] rd;
    reg_access(1'b1, addr, wdata, rd);
    if (addr == ADDR_TERM_COUNT) cur_terms = wdata[CNT_W-1:0];
    reg_access(1'b0, ADDR_TERM_COUNT, '0, rd);
    if (rd !== DATA_W'(cur_terms))
      flag_mismatch($sformatf("term_count read %0d, want %0d", rd, cur_terms));
  endtask

  task automatic offer_angle(input logic signed [DEG_W-1:0] ang, input logic known,
                             input logic [OUT_W-1:0] sine);
    int gap;
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    angle_degrees_i <= ang;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_sines.push_back(known ? sine : taylor_sine(ang, cur_terms));
  endtask

  task automatic drain();
    while (pending_sines.size() != 0) @(posedge clk_i);
  endtask

  // output side stall generator
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sines.size() == 0) begin
        flag_mismatch($sformatf("unexpected word sine_value=%h", sine_value_o));
      end else begin
        if (sine_value_o !== pending_sines[0])
          flag_mismatch($sformatf("sine_value=%h, want %h", sine_value_o, pending_sines[0]));
        void'(pending_sines.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] wdata, rd;
    logic [CNT_W-1:0]  cnt;
    int unsigned       r, p, k;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_access(1'b0, ADDR_TERM_COUNT, '0, rd);
    if (rd !== DATA_W'(TERM_COUNT_RESET))
      flag_mismatch($sformatf("term_count after reset %0d", rd));

    for (r = 0; r < N_DIR; r++) begin
      if (DIR_TAB[r].terms != cur_terms) begin
        in_valid_i <= 1'b0;
        drain();
        write_terms(ADDR_TERM_COUNT, DATA_W'(DIR_TAB[r].terms));
      end
      offer_angle(DIR_TAB[r].angle, DIR_TAB[r].known, DIR_TAB[r].sine);
    end

    for (p = 0; p < N_PHASES; p++) begin
      in_valid_i <= 1'b0;
      drain();
      if (p == N_PHASES - 1) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      case (p)
        0:       cnt = CNT_W'(16);
        1:       cnt = CNT_W'(0);
        2:       cnt = CNT_W'(31);
        3:       cnt = CNT_W'(1);
        default: cnt = CNT_W'($urandom_range(0, 31));
      endcase
      wdata = $urandom();
      wdata[CNT_W-1:0] = cnt;
      write_terms(ADDR_TERM_COUNT, wdata);
      if (p == PH_SPARE) write_terms(ADDR_SPARE, $urandom());  // must not touch term_count
      if (p == PH_HOLD) long_hold_req = 1'b1;
      for (k = 0; k < PHASE_WORDS; k++) offer_angle(pick_angle(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_sines.size() != 0) flag_mismatch("words still outstanding");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
